@@ sv/adnp_pkg.sv @@
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared widths, character codes and the result record of the ASCII decimal
// number parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

    localparam int CH_W   = 8;
    localparam int SIG_W  = 60;
    localparam int EXP_W  = 16;
    localparam int EACC_W = 14;
    localparam int CNT_W  = 5;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    localparam logic [SIG_W-1:0]  SIG_LIMIT   = {SIG_W{1'b1}};
    localparam logic [EXP_W-1:0]  SCALE_MAX   = 16'sd10000;
    localparam logic [EXP_W-1:0]  SCALE_MIN   = -16'sd10000;
    localparam logic [EACC_W-1:0] EXP_LIMIT   = 14'd9999;

    localparam logic [CH_W-1:0] CHR_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CHR_CR    = 8'd13;
    localparam logic [CH_W-1:0] CHR_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHR_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CHR_E_UP  = 8'h45;
    localparam logic [CH_W-1:0] CHR_E_LO  = 8'h65;

    typedef struct packed {
        logic                    negative;
        logic [SIG_W-1:0]        significand;
        logic signed [EXP_W-1:0] decimal_exponent;
        logic                    inexact;
    } result_t;

endpackage

@@ sv/adnp_scan.sv @@
// ----------------------------------------------------------------------------
// adnp_scan
// Scanner state and per-character update: sign, significand, digit scale and
// exponent accumulation; produces the finished result on the last character.
// ----------------------------------------------------------------------------
module adnp_scan
    import adnp_pkg::*;
#(
    parameter int MAX_DIGITS = 18
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [CH_W-1:0] ch,
    input  logic            last,
    output result_t         result
);

    typedef enum logic [2:0] {
        MODE_WS    = 3'd0,
        MODE_INT   = 3'd1,
        MODE_FRAC  = 3'd2,
        MODE_EMARK = 3'd3,
        MODE_ESIGN = 3'd4,
        MODE_EDIG  = 3'd5,
        MODE_STOP  = 3'd6
    } mode_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    mode_t                   mode_reg, mode_next;
    logic [SIG_W-1:0]        mant_reg, mant_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [EXP_W-1:0] scale_reg, scale_next;
    logic [EACC_W-1:0]       exp_reg, exp_next;
    logic                    exp_minus_reg, exp_minus_next;
    logic                    mant_minus_reg, mant_minus_next;
    logic                    lost_reg, lost_next;

    logic                    is_digit;
    logic                    is_emark;
    logic                    is_sign;
    logic                    is_space;
    logic [3:0]              dig;
    logic [SIG_W+3:0]        sig_prod;
    logic                    sig_fits;
    logic                    sig_lead_zero;
    logic [EACC_W+2:0]       exp_prod;
    logic                    exp_over;
    logic signed [EXP_W-1:0] exp_signed;

    assign is_digit = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
    assign is_emark = (ch == CHR_E_UP) || (ch == CHR_E_LO);
    assign is_sign  = (ch == CHR_PLUS) || (ch == CHR_MINUS);
    assign is_space = ((ch >= CHR_TAB) && (ch <= CHR_CR)) || (ch == CHR_SPACE);
    assign dig      = is_digit ? 4'(ch - CHR_ZERO) : 4'd0;

    // mant * 10 + d
    assign sig_prod = ({4'd0, mant_reg} << 3) + ({4'd0, mant_reg} << 1)
                      + (SIG_W+4)'(dig);
    assign sig_fits = (cnt_reg < MAX_CNT) && (sig_prod <= {4'd0, SIG_LIMIT});
    assign sig_lead_zero = (mant_reg == '0) && (cnt_reg == '0) && (dig == 4'd0);

    assign exp_prod = ({3'd0, exp_reg} << 3) + ({3'd0, exp_reg} << 1)
                      + (EACC_W+3)'(dig);
    assign exp_over = exp_prod > {3'd0, EXP_LIMIT};

    always_comb
    begin
        logic take_sig;
        logic in_frac;
        logic take_exp;
        logic scale_dn;
        logic scale_up;
        take_sig        = 1'b0;
        in_frac         = 1'b0;
        take_exp        = 1'b0;
        scale_dn        = 1'b0;
        scale_up        = 1'b0;
        mode_next       = mode_reg;
        mant_next       = mant_reg;
        cnt_next        = cnt_reg;
        scale_next      = scale_reg;
        exp_next        = exp_reg;
        exp_minus_next  = exp_minus_reg;
        mant_minus_next = mant_minus_reg;
        lost_next       = lost_reg;

        unique case (mode_reg)
            MODE_WS:
            begin
                priority if (is_space)
                begin
                    mode_next = MODE_WS;
                end
                else if (is_sign)
                begin
                    mant_minus_next = (ch == CHR_MINUS);
                    mode_next       = MODE_INT;
                end
                else if (is_digit)
                begin
                    take_sig  = 1'b1;
                    mode_next = MODE_INT;
                end
                else if (ch == CHR_POINT)
                begin
                    mode_next = MODE_FRAC;
                end
                else if (is_emark)
                begin
                    mode_next = MODE_EMARK;
                end
                else
                begin
                    mode_next = MODE_STOP;
                end
            end
            MODE_INT:
            begin
                priority if (is_digit)
                begin
                    take_sig = 1'b1;
                end
                else if (ch == CHR_POINT)
                begin
                    mode_next = MODE_FRAC;
                end
                else if (is_emark)
                begin
                    mode_next = MODE_EMARK;
                end
                else
                begin
                    mode_next = MODE_STOP;
                end
            end
            MODE_FRAC:
            begin
                priority if (is_digit)
                begin
                    take_sig = 1'b1;
                    in_frac  = 1'b1;
                end
                else if (is_emark)
                begin
                    mode_next = MODE_EMARK;
                end
                else
                begin
                    mode_next = MODE_STOP;
                end
            end
            MODE_EMARK:
            begin
                priority if (is_sign)
                begin
                    exp_minus_next = (ch == CHR_MINUS);
                    mode_next      = MODE_ESIGN;
                end
                else if (is_digit)
                begin
                    take_exp  = 1'b1;
                    mode_next = MODE_EDIG;
                end
                else
                begin
                    mode_next = MODE_STOP;
                end
            end
            MODE_ESIGN, MODE_EDIG:
            begin
                if (is_digit)
                begin
                    take_exp  = 1'b1;
                    mode_next = MODE_EDIG;
                end
                else
                begin
                    mode_next = MODE_STOP;
                end
            end
            default:
            begin
                mode_next = MODE_STOP;
            end
        endcase

        if (take_sig)
        begin
            priority if (sig_lead_zero)
            begin
                scale_dn = in_frac;
            end
            else if (sig_fits)
            begin
                mant_next = sig_prod[SIG_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                scale_dn  = in_frac;
            end
            else
            begin
                lost_next = 1'b1;
                scale_up  = !in_frac;
            end
        end

        if (scale_dn)
        begin
            if (scale_reg == SCALE_MIN)
            begin
                lost_next = 1'b1;
            end
            else
            begin
                scale_next = scale_reg - 16'sd1;
            end
        end
        if (scale_up)
        begin
            if (scale_reg == SCALE_MAX)
            begin
                lost_next = 1'b1;
            end
            else
            begin
                scale_next = scale_reg + 16'sd1;
            end
        end

        if (take_exp)
        begin
            if (exp_over)
            begin
                exp_next  = EXP_LIMIT;
                lost_next = 1'b1;
            end
            else
            begin
                exp_next = exp_prod[EACC_W-1:0];
            end
        end
    end

    assign exp_signed = exp_minus_next ? -$signed({2'b00, exp_next})
                                       :  $signed({2'b00, exp_next});

    assign result.negative         = mant_minus_next;
    assign result.significand      = mant_next;
    assign result.decimal_exponent = exp_signed + scale_next;
    assign result.inexact          = lost_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_WS;
            mant_reg       <= '0;
            cnt_reg        <= '0;
            scale_reg      <= '0;
            exp_reg        <= '0;
            exp_minus_reg  <= 1'b0;
            mant_minus_reg <= 1'b0;
            lost_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                mode_reg       <= MODE_WS;
                mant_reg       <= '0;
                cnt_reg        <= '0;
                scale_reg      <= '0;
                exp_reg        <= '0;
                exp_minus_reg  <= 1'b0;
                mant_minus_reg <= 1'b0;
                lost_reg       <= 1'b0;
            end
            else
            begin
                mode_reg       <= mode_next;
                mant_reg       <= mant_next;
                cnt_reg        <= cnt_next;
                scale_reg      <= scale_next;
                exp_reg        <= exp_next;
                exp_minus_reg  <= exp_minus_next;
                mant_minus_reg <= mant_minus_next;
                lost_reg       <= lost_next;
            end
        end
    end

endmodule

@@ sv/ascii_decimal_number_parser_top.sv @@
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_top
// Streams ASCII characters in, one per request, and returns sign, decimal
// significand and decimal exponent when the last character arrives.
//
//   channel   dir   tdata fields (lsb first)                      tlast
//   s_axis    in    ch[7:0]                                       last
//   m_axis    out   negative, significand[59:0],                  -
//                   decimal_exponent[15:0], inexact, 2'b0 pad
//
// One character per cycle unless a last character waits on a pending result;
// the scan update (x10 plus digit) sits between the input register and the
// scanner state, and each result is registered in the output register for m_axis.
// rst_n clears the scanner to whitespace skipping and empties both registers.
// A pending result holds off only a following last character; other
// characters keep flowing while m_axis stalls.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_top
    import adnp_pkg::*;
#(
    parameter int MAX_DIGITS = 18
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // ch[7:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // negative, significand,
                                                   // decimal_exponent, inexact
);

    logic            in_valid_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            in_last_reg;
    logic            step;
    result_t         scan_result;
    result_t         out_reg;
    logic            out_valid_reg;

    assign step = in_valid_reg
                  && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ch_reg   <= s_axis_tdata[CH_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    adnp_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .ch     (in_ch_reg),
        .last   (in_last_reg),
        .result (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_reg <= scan_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_reg.inexact,
                            out_reg.decimal_exponent,
                            out_reg.significand,
                            out_reg.negative};

endmodule
